[rtl/protobuf_field_encoder_defines.svh]
// ----------------------------------------------------------------------------
// protobuf field encoder assertion macros
// concurrent checks on clock, with and without the reset guard
// ----------------------------------------------------------------------------
`ifndef PROTOBUF_FIELD_ENCODER_DEFINES_SVH
`define PROTOBUF_FIELD_ENCODER_DEFINES_SVH

`ifndef ASSERT_OFF
// check held off while reset is high
`define PFE_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// check that also runs through reset
`define PFE_ASSERT_RST(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);
`else
`define PFE_ASSERT(lbl, prop, msg)
`define PFE_ASSERT_RST(lbl, prop, msg)
`endif

`endif

[rtl/pfe_pkg.sv]
// ----------------------------------------------------------------------------
// pfe_pkg
// commands, wire types and the work descriptor shared by front, queue and back
// ----------------------------------------------------------------------------
package pfe_pkg;

   typedef enum logic [2:0] {
      CMD_BOOL    = 3'd0,
      CMD_UVARINT = 3'd1,
      CMD_ZIGZAG  = 3'd2,
      CMD_FIXED32 = 3'd3,
      CMD_FIXED64 = 3'd4,
      CMD_STRING  = 3'd5,
      CMD_PAYLOAD = 3'd6
   } cmd_type;

   localparam logic [2:0] WT_VARINT   = 3'd0;
   localparam logic [2:0] WT_FIXED64  = 3'd1;
   localparam logic [2:0] WT_LENDELIM = 3'd2;
   localparam logic [2:0] WT_FIXED32  = 3'd5;

   localparam logic [3:0] LEN_PAYLOAD = 4'd1;
   localparam logic [3:0] LEN_FIXED32 = 4'd4;
   localparam logic [3:0] LEN_FIXED64 = 4'd8;

   // one classified field, ready for serialising
   typedef struct packed {
      logic        has_key;
      logic [31:0] key;
      logic        fixed;    // little-endian raw bytes instead of varint
      logic [3:0]  fix_len;
      logic [63:0] body;
   } entry_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

endpackage

[rtl/pfe_front.sv]
// ----------------------------------------------------------------------------
// pfe_front
// classifies one request into key, body and body form
// ----------------------------------------------------------------------------
module pfe_front
   import pfe_pkg::*;
(
   input  logic [2:0]  cmd,
   input  logic [28:0] field_number,
   input  logic [63:0] value,
   output entry_type   entry,
   output logic        keep
);

   logic [2:0] wire_type;

   always_comb begin
      wire_type     = WT_VARINT;
      keep          = 1'b1;
      entry.has_key = 1'b1;
      entry.fixed   = 1'b0;
      entry.fix_len = LEN_PAYLOAD;
      entry.body    = value;
      case (cmd_type'(cmd))
         CMD_BOOL: begin
            entry.body = {63'd0, |value};
         end
         CMD_UVARINT: begin
            entry.body = value;
         end
         CMD_ZIGZAG: begin
            entry.body = {value[62:0], 1'b0} ^ {64{value[63]}};
         end
         CMD_FIXED32: begin
            wire_type     = WT_FIXED32;
            entry.fixed   = 1'b1;
            entry.fix_len = LEN_FIXED32;
            entry.body    = {32'd0, value[31:0]};
         end
         CMD_FIXED64: begin
            wire_type     = WT_FIXED64;
            entry.fixed   = 1'b1;
            entry.fix_len = LEN_FIXED64;
         end
         CMD_STRING: begin
            wire_type = WT_LENDELIM;
         end
         CMD_PAYLOAD: begin
            entry.has_key = 1'b0;
            entry.fixed   = 1'b1;
            entry.fix_len = LEN_PAYLOAD;
            entry.body    = {56'd0, value[7:0]};
         end
         default: begin
            // undefined command produces nothing
            keep = 1'b0;
         end
      endcase
      entry.key = {field_number, wire_type};
   end

endmodule

[rtl/pfe_queue.sv]
// ----------------------------------------------------------------------------
// pfe_queue
// small fifo of classified entries between front and back
// ----------------------------------------------------------------------------
module pfe_queue
   import pfe_pkg::*;
#(
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  entry_type        push_entry,
   input  logic             pop,
   output entry_type        head,
   output queue_status_type status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   entry_type        slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == FULL_CNT);
   assign head         = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

[rtl/pfe_back.sv]
// ----------------------------------------------------------------------------
// pfe_back
// serialises key and body of each entry into bytes, one per cycle while the output is not stalled
// ----------------------------------------------------------------------------
module pfe_back
   import pfe_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  entry_type        head,
   input  queue_status_type q_status,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [7:0]       rsp_byte,
   output logic             rsp_last
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_KEY,
      ST_BODY
   } state_type;

   state_type   state_ff, state_in;
   logic [31:0] key_ff, key_in;
   logic [63:0] body_ff, body_in;
   logic        fixed_ff, fixed_in;
   logic [3:0]  len_ff, len_in;
   logic        valid_ff, valid_in;
   logic [7:0]  byte_ff, byte_in;
   logic        last_ff, last_in;

   logic out_free;
   logic emit;
   logic more_key;
   logic more_body;
   logic done;

   assign out_free  = !valid_ff || rsp_ready;
   assign emit      = out_free && (state_ff != ST_IDLE);
   assign more_key  = |key_ff[31:7];
   assign more_body = |body_ff[63:7];

   assign rsp_valid = valid_ff;
   assign rsp_byte  = byte_ff;
   assign rsp_last  = last_ff;

   always_comb begin
      state_in = state_ff;
      key_in   = key_ff;
      body_in  = body_ff;
      fixed_in = fixed_ff;
      len_in   = len_ff;
      byte_in  = byte_ff;
      last_in  = last_ff;
      valid_in = rsp_ready ? 1'b0 : valid_ff;
      done     = 1'b0;
      pop      = 1'b0;

      if (emit) begin
         valid_in = 1'b1;
         case (state_ff)
            ST_KEY: begin
               byte_in = {more_key, key_ff[6:0]};
               last_in = 1'b0;
               key_in  = key_ff >> 7;
               if (!more_key) begin
                  state_in = ST_BODY;
               end
            end
            ST_BODY: begin
               if (fixed_ff) begin
                  byte_in = body_ff[7:0];
                  last_in = (len_ff == LEN_PAYLOAD);
                  body_in = body_ff >> 8;
                  len_in  = len_ff - 4'd1;
               end else begin
                  byte_in = {more_body, body_ff[6:0]};
                  last_in = !more_body;
                  body_in = body_ff >> 7;
               end
               done = last_in;
            end
            default: begin
               state_in = ST_IDLE;
            end
         endcase
      end

      // load the next entry on the final byte so bytes run without a gap
      if (state_ff == ST_IDLE || done) begin
         if (!q_status.empty) begin
            pop      = 1'b1;
            state_in = head.has_key ? ST_KEY : ST_BODY;
            key_in   = head.key;
            body_in  = head.body;
            fixed_in = head.fixed;
            len_in   = head.fix_len;
         end else begin
            state_in = ST_IDLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
      key_ff   <= key_in;
      body_ff  <= body_in;
      fixed_ff <= fixed_in;
      len_ff   <= len_in;
      byte_ff  <= byte_in;
      last_ff  <= last_in;
   end

endmodule

[rtl/protobuf_field_encoder.sv]
// a request passes through the entry queue and the back end registers to the byte output
// throughput: one byte per cycle while the output is not stalled; an item is 1 to 15 bytes
// the byte serialiser in the back end sets this figure, the entry queue hides item changes
// undefined commands are taken and dropped without producing bytes
// reset: synchronous, active high; empties the queue and the output register
// ----------------------------------------------------------------------------
// protobuf_field_encoder
// wire-format field encoder: key varint then varint or fixed bytes, or bare payload bytes
// ----------------------------------------------------------------------------
`include "protobuf_field_encoder_defines.svh"

module protobuf_field_encoder
   import pfe_pkg::*;
#(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [95:0] req_tdata,   // field_number [28:0], value [92:29], zero fill
   input  logic [2:0]  req_tuser,   // cmd [2:0]
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // out_byte [7:0]
   output logic        rsp_tlast
);

   entry_type        front_entry;
   logic             front_keep;
   entry_type        q_head;
   queue_status_type q_status;
   logic             q_push;
   logic             q_pop;

   // a transfer is taken whenever the queue has room
   assign req_tready = !q_status.full;
   assign q_push     = req_tvalid && req_tready && front_keep;

   // front: decode command, build key and body form
   pfe_front u_front (
      .cmd          (req_tuser),
      .field_number (req_tdata[28:0]),
      .value        (req_tdata[92:29]),
      .entry        (front_entry),
      .keep         (front_keep)
   );

   // queue: decouples request acceptance from byte output
   pfe_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (front_entry),
      .pop        (q_pop),
      .head       (q_head),
      .status     (q_status)
   );

   // back: byte serialiser with registered output
   pfe_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (q_head),
      .q_status  (q_status),
      .pop       (q_pop),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_byte  (rsp_tdata),
      .rsp_last  (rsp_tlast)
   );

   // no entry is taken from an empty queue
   `PFE_ASSERT(a_pop_not_empty, q_pop |-> !q_status.empty, "pop from empty queue")
   // no entry is written into a full queue
   `PFE_ASSERT(a_push_not_full, q_push |-> !q_status.full, "push into full queue")
   // output register is empty right after reset
   `PFE_ASSERT_RST(a_reset_idle, reset |=> !rsp_tvalid, "response valid after reset")

endmodule

[verif/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// regression bench for the protocol-buffer field encoder: directed and random
// field items go in on the request stream, every encoded byte is checked
// against a byte-exact predictor held in a small scoreboard
// ----------------------------------------------------------------------------
module tb_top;
   import pfe_pkg::*;

   // command code that the block takes and drops without output
   localparam logic [2:0]  CMD_UNDEFINED = 3'd7;
   localparam logic [28:0] FIELD_MAX     = 29'h1fff_ffff;
   localparam logic [63:0] ALL_ONES      = 64'hffff_ffff_ffff_ffff;
   localparam logic [63:0] SIGN_ONLY     = 64'h8000_0000_0000_0000;

   localparam int unsigned ITEM_TARGET   = 370;
   localparam int unsigned HOLD_AT_ITEM  = 60;    // receiver hold-off starts here
   localparam int unsigned HOLD_CYCLES   = 300;
   localparam int unsigned STEADY_FIRST  = 200;   // no idling on either side
   localparam int unsigned STEADY_LAST   = 280;
   localparam int unsigned DRAIN_CYCLES  = 8;     // time for stray bytes to reach the output
   localparam int unsigned STALL_LIMIT   = 2000;  // cycles with no transfer at all

   // one byte on the response stream
   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } encoded_byte_type;

   // -------------------------------------------------------------------------
   // scoreboard: encodes each accepted request into the bytes it must produce
   // and checks the response stream against them in order
   // -------------------------------------------------------------------------
   class encoding_scoreboard;
      encoded_byte_type expected_bytes[$];
      logic [7:0]       field_bytes[$];
      int unsigned      mismatches;
      int unsigned      bytes_checked;

      function void put_varint(logic [63:0] v);
         while (v > 64'h7f) begin
            field_bytes.push_back({1'b1, v[6:0]});
            v = v >> 7;
         end
         field_bytes.push_back({1'b0, v[6:0]});
      endfunction

      function void put_le(logic [63:0] v, int unsigned count);
         for (int unsigned i = 0; i < count; i++) begin
            field_bytes.push_back(v[8*i +: 8]);
         end
      endfunction

      // key is (field number << 3) | wire type, 32 bits wide
      function void put_key(logic [28:0] field, logic [2:0] wire_type);
         put_varint({32'd0, field, wire_type});
      endfunction

      function void encode_field(logic [2:0] cmd, logic [28:0] field, logic [63:0] value);
         encoded_byte_type entry;
         field_bytes.delete();
         case (cmd)
            CMD_BOOL: begin
               put_key(field, WT_VARINT);
               field_bytes.push_back({7'd0, value != 64'd0});
            end
            CMD_UVARINT: begin
               put_key(field, WT_VARINT);
               put_varint(value);
            end
            CMD_ZIGZAG: begin
               put_key(field, WT_VARINT);
               put_varint((value << 1) ^ {64{value[63]}});
            end
            CMD_FIXED32: begin
               put_key(field, WT_FIXED32);
               put_le(value, 4);
            end
            CMD_FIXED64: begin
               put_key(field, WT_FIXED64);
               put_le(value, 8);
            end
            CMD_STRING: begin
               put_key(field, WT_LENDELIM);
               put_varint(value);
            end
            CMD_PAYLOAD: begin
               field_bytes.push_back(value[7:0]);
            end
            default: begin
            end
         endcase
         foreach (field_bytes[i]) begin
            entry.data = field_bytes[i];
            entry.last = (i == field_bytes.size() - 1);
            expected_bytes.push_back(entry);
         end
      endfunction

      function void check_byte(logic [7:0] data, logic last);
         encoded_byte_type want;
         if (expected_bytes.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected byte %02h last %0b with nothing outstanding", data, last);
         end else begin
            want = expected_bytes.pop_front();
            bytes_checked++;
            if (want.data !== data || want.last !== last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("byte mismatch: expected %02h last %0b, got %02h last %0b",
                           want.data, want.last, data, last);
            end
         end
      endfunction

      function int unsigned pending();
         return expected_bytes.size();
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [95:0] req_tdata;   // field_number [28:0], value [92:29], zero fill
   logic [2:0]  req_tuser;   // cmd [2:0]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;   // out_byte [7:0]
   logic        rsp_tlast;

   encoding_scoreboard sb;

   // shared between sender and receiver
   logic        hold_request;
   logic        steady_stretch;
   int unsigned field_items;
   int unsigned items_by_cmd[8];

   protobuf_field_encoder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // everything known from time zero, reset held high until the stimulus releases it
   initial begin
      sb             = new();
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      req_tuser      = '0;
      rsp_tready     = 1'b0;
      hold_request   = 1'b0;
      steady_stretch = 1'b0;
      field_items    = 0;
   end

   // -------------------------------------------------------------------------
   // sender: offer one item, with an occasional random gap in front of it;
   // inputs move on the falling edge, the transfer is seen on the rising edge
   // -------------------------------------------------------------------------
   task automatic send_item(input logic [2:0] cmd, input logic [28:0] field,
                            input logic [63:0] value);
      if (!steady_stretch && $urandom_range(0, 99) < 10) begin
         repeat ($urandom_range(1, 4)) begin
            @(negedge clock);
            req_tvalid = 1'b0;
         end
      end
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tdata  = {3'b000, value, field};
      req_tuser  = cmd;
      do @(posedge clock); while (!req_tready);
      sb.encode_field(cmd, field, value);
      items_by_cmd[cmd]++;
      if (cmd != CMD_UNDEFINED)
         field_items++;
   endtask

   // mostly short field numbers so one- and two-byte keys dominate
   function automatic logic [28:0] random_field_number();
      case ($urandom_range(0, 2))
         0:       return 29'($urandom_range(0, 15));
         1:       return 29'($urandom_range(0, 2047));
         default: return 29'($urandom);
      endcase
   endfunction

   // random significant width so every varint length turns up
   function automatic logic [63:0] random_value();
      logic [63:0] bits;
      int unsigned width;
      bits  = {$urandom, $urandom};
      width = $urandom_range(0, 64);
      if (width < 64)
         bits &= (64'd1 << width) - 64'd1;
      return bits;
   endfunction

   // -------------------------------------------------------------------------
   // receiver: random back-pressure, one long hold-off counted here so the
   // entry queue fills and the request side stalls, and a stretch with none
   // -------------------------------------------------------------------------
   initial begin
      int unsigned hold_left;
      logic        hold_done;
      hold_left = 0;
      hold_done = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request && !hold_done) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            rsp_tready = 1'b0;
            hold_left--;
         end else if (steady_stretch) begin
            rsp_tready = 1'b1;
         end else begin
            rsp_tready = ($urandom_range(0, 99) >= 10);
         end
      end
   end

   // every response transfer goes straight to the scoreboard
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_byte(rsp_tdata, rsp_tlast);
   end

   // watchdog: too long without any transfer on either side ends the run
   initial begin
      int unsigned quiet_cycles;
      quiet_cycles = 0;
      wait (reset == 1'b0);
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("protobuf_field_encoder regression: fail");
      $finish;
   end

   // -------------------------------------------------------------------------
   // stimulus
   // -------------------------------------------------------------------------
   initial begin
      int unsigned pick;
      int unsigned burst;
      logic [2:0]  cmd;
      logic [63:0] value;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: field number edges (one-, two- and five-byte keys), varint
      // length edges, zigzag sign cases, fixed widths, header plus payload
      send_item(CMD_BOOL,    29'd0,     64'd0);
      send_item(CMD_BOOL,    FIELD_MAX, 64'd1);
      send_item(CMD_BOOL,    29'd15,    SIGN_ONLY);      // non-zero maps to one
      send_item(CMD_UVARINT, 29'd16,    64'd0);
      send_item(CMD_UVARINT, 29'd1,     64'd127);
      send_item(CMD_UVARINT, 29'd2,     64'd128);
      send_item(CMD_UVARINT, FIELD_MAX, ALL_ONES);       // longest item, fifteen bytes
      send_item(CMD_ZIGZAG,  29'd3,     64'd0);
      send_item(CMD_ZIGZAG,  29'd4,     ALL_ONES);       // minus one
      send_item(CMD_ZIGZAG,  29'd5,     SIGN_ONLY);      // most negative
      send_item(CMD_ZIGZAG,  29'd6,     ~SIGN_ONLY);     // most positive
      send_item(CMD_ZIGZAG,  29'd7,     64'd1);
      send_item(CMD_FIXED32, FIELD_MAX, ALL_ONES);       // upper half must be dropped
      send_item(CMD_FIXED32, 29'd0,     64'h0123_4567_89ab_cdef);
      send_item(CMD_FIXED64, 29'd1,     ALL_ONES);
      send_item(CMD_FIXED64, 29'd2047,  64'h0123_4567_89ab_cdef);
      send_item(CMD_STRING,  29'd9,     64'd0);          // empty string
      send_item(CMD_STRING,  29'd10,    64'd3);
      send_item(CMD_PAYLOAD, FIELD_MAX, ALL_ONES);       // field number ignored
      send_item(CMD_PAYLOAD, 29'd0,     64'd0);
      send_item(CMD_PAYLOAD, 29'h0aaa_aaaa, 64'h5555_5555_5555_55a5);
      send_item(CMD_UNDEFINED, FIELD_MAX, ALL_ONES);     // dropped, no bytes
      send_item(CMD_STRING,  29'h1555_5555, 64'd300);
      send_item(CMD_UNDEFINED, 29'd0,   64'd0);

      // random: mostly scalar fields, string headers with their payload,
      // and a little noise (truncated strings, stray bytes, bad commands)
      while (field_items < ITEM_TARGET) begin
         hold_request   = (field_items >= HOLD_AT_ITEM);
         steady_stretch = (field_items >= STEADY_FIRST && field_items < STEADY_LAST);
         pick = $urandom_range(0, 99);
         if (pick < 30) begin
            if ($urandom_range(0, 4) == 0) begin
               value = random_value();
               burst = $urandom_range(0, 3);
            end else begin
               value = 64'($urandom_range(0, 6));
               burst = {29'd0, value[2:0]};
            end
            send_item(CMD_STRING, random_field_number(), value);
            repeat (burst)
               send_item(CMD_PAYLOAD, random_field_number(), {$urandom, $urandom});
         end else if (pick < 33) begin
            send_item(CMD_UNDEFINED, random_field_number(), {$urandom, $urandom});
         end else if (pick < 36) begin
            send_item(CMD_PAYLOAD, random_field_number(), {$urandom, $urandom});
         end else begin
            cmd   = 3'($urandom_range(0, 4));
            value = random_value();
            if (cmd == CMD_BOOL && $urandom_range(0, 1) == 0)
               value = 64'd0;
            if (cmd == CMD_ZIGZAG && $urandom_range(0, 1) == 0)
               value = ~value;                           // small negatives
            if (cmd == CMD_FIXED64 || cmd == CMD_FIXED32)
               value = {$urandom, $urandom};
            send_item(cmd, random_field_number(), value);
         end
      end
      steady_stretch = 1'b0;
      @(negedge clock);
      req_tvalid = 1'b0;

      // drain, then give stray bytes a chance to show up
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d field items: bool %0d, uvarint %0d, zigzag %0d, fixed32 %0d,",
               field_items, items_by_cmd[CMD_BOOL], items_by_cmd[CMD_UVARINT],
               items_by_cmd[CMD_ZIGZAG], items_by_cmd[CMD_FIXED32]);
      $display("  fixed64 %0d, string %0d, payload %0d, dropped %0d; %0d bytes checked",
               items_by_cmd[CMD_FIXED64], items_by_cmd[CMD_STRING],
               items_by_cmd[CMD_PAYLOAD], items_by_cmd[CMD_UNDEFINED], sb.bytes_checked);
      if (sb.mismatches > 10)
         $display("%0d mismatches in total", sb.mismatches);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("protobuf_field_encoder regression: pass");
      end else begin
         $display("protobuf_field_encoder regression: fail");
      end
      $finish;
   end

endmodule

[protobuf_field_encoder.f]
+incdir+rtl
rtl/pfe_pkg.sv
rtl/pfe_front.sv
rtl/pfe_queue.sv
rtl/pfe_back.sv
rtl/protobuf_field_encoder.sv
verif/tb_top.sv
